// ===== rtl/ldp_pkg.sv =====
// Shared types and constants for the label dominance prune unit.
// Holds the stored label layout, compare results and interface widths.
// No dependencies.
`default_nettype none
package ldp_pkg;

    localparam int DEF_MAX_LABELS = 32;
    localparam int DEF_NUM_RES    = 4;
    localparam int DEF_NUM_NODES  = 64;
    localparam int DEF_MAX_PATH   = 8;

    localparam int IN_DATA_W  = 240;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam int RES_LANES = 4;
    localparam int RES_W     = 16;
    localparam int MAP_W     = 64;
    localparam int PATH_W    = 64;
    localparam int PATH_BYTES = 8;

    // Configuration register indexes
    localparam logic CFG_CRIT_IDX = 1'b0;
    localparam logic CFG_ELEM     = 1'b1;

    // Request kinds
    localparam logic REQ_CHECK  = 1'b0;
    localparam logic REQ_APPEND = 1'b1;

    typedef struct packed {
        logic [3:0]  path_len;
        logic [5:0]  vertex;
        logic [63:0] path;
        logic [63:0] umap;
        logic [63:0] res;
        logic [31:0] weight;
    } entry_t;

    typedef struct packed {
        logic same;
        logic new_dom;
        logic ent_dom;
    } cmp_t;

endpackage
`default_nettype wire

// ===== rtl/ldp_store.sv =====
// Label store: one write port and one registered read port.
// Depends on ldp_pkg for the entry layout.
`default_nettype none
module ldp_store
    import ldp_pkg::*;
#(
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    localparam int IDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1
)(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire entry_t           wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output entry_t                rdata
);

    entry_t mem [MAX_LABELS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/ldp_cmp.sv =====
// Compare unit: equality and dominance in both senses between the
// held label and one stored entry. Depends on ldp_pkg.
`default_nettype none
module ldp_cmp
    import ldp_pkg::*;
(
    input  wire entry_t     lbl,
    input  wire entry_t     ent,
    input  wire logic       bwd,
    input  wire logic [1:0] crit,
    input  wire logic       elem,
    output cmp_t            res
);

    logic [RES_LANES-1:0] r_le_ne;
    logic [RES_LANES-1:0] r_le_en;
    logic                 w_eq;
    logic                 r_eq;
    logic                 ok_ne;
    logic                 ok_en;
    logic                 sub_fail_ne;
    logic                 sub_fail_en;
    logic                 maps_set;

    always_comb
    begin
        for (int i = 0; i < RES_LANES; i++)
        begin
            if (bwd && crit == 2'(i))
            begin
                r_le_ne[i] = $signed(lbl.res[i*RES_W +: RES_W]) >=
                             $signed(ent.res[i*RES_W +: RES_W]);
                r_le_en[i] = $signed(ent.res[i*RES_W +: RES_W]) >=
                             $signed(lbl.res[i*RES_W +: RES_W]);
            end
            else
            begin
                r_le_ne[i] = $signed(lbl.res[i*RES_W +: RES_W]) <=
                             $signed(ent.res[i*RES_W +: RES_W]);
                r_le_en[i] = $signed(ent.res[i*RES_W +: RES_W]) <=
                             $signed(lbl.res[i*RES_W +: RES_W]);
            end
        end
        w_eq = lbl.weight == ent.weight;
        r_eq = lbl.res == ent.res;
        maps_set = elem && (lbl.umap != '0) && (ent.umap != '0);
        sub_fail_ne = maps_set && ((lbl.umap & ~ent.umap) != '0);
        sub_fail_en = maps_set && ((ent.umap & ~lbl.umap) != '0);
        ok_ne = !(w_eq && r_eq) && ($signed(lbl.weight) <= $signed(ent.weight)) &&
                (&r_le_ne) && !sub_fail_ne;
        ok_en = !(w_eq && r_eq) && ($signed(ent.weight) <= $signed(lbl.weight)) &&
                (&r_le_en) && !sub_fail_en;
        res.same    = w_eq && r_eq && (lbl.vertex == ent.vertex) &&
                      (lbl.path_len == ent.path_len) && (lbl.path == ent.path);
        res.new_dom = ok_ne;
        res.ent_dom = ok_en;
    end

endmodule
`default_nettype wire

// ===== rtl/label_dominance_prune_unit.sv =====
// Label dominance prune unit: top level with the request sequencer.
// Depends on ldp_pkg, ldp_store and ldp_cmp.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one request item. s_tuser holds
//   req_type (bit 0) and search_direction (bit 1). An append writes the label
//   at the end of the store. A check streams the store through
//   the compare unit, one entry per cycle from the single read port, writing
//   kept entries back down to close gaps. The next request is accepted only
//   once the result of the last one is loaded into the output register.
//   m_tvalid/m_tready/m_tdata carry one result item per request, held in an
//   output register; while the receiver stalls the finished result waits
//   there and the sequencer holds before loading the next one.
//   cfg_we/cfg_addr/cfg_data write critical_resource_index (0) and
//   elementary_mode (1); write only while idle.
//   Reset empties the store (count to zero) and clears the control registers;
//   the store contents, the held label and the result data are not cleared.
`default_nettype none
module label_dominance_prune_unit
    import ldp_pkg::*;
#(
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    parameter int NUM_RES    = DEF_NUM_RES,
    parameter int NUM_NODES  = DEF_NUM_NODES,
    parameter int MAX_PATH   = DEF_MAX_PATH
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // vertex_id, label_weight, res_a, res_b, res_c, res_d, unreachable_map,
    // path_nodes, path_len, zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // req_type, search_direction
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // is_dominated, removed_count, stored_count, store_full, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_addr,
    input  wire logic [1:0]            cfg_data
);

    localparam int IDX_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
    localparam int CNT_W = $clog2(MAX_LABELS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             pend_reg, pend_next;
    logic             dom_reg, dom_next;
    logic             full_reg, full_next;
    logic             bwd_reg, bwd_next;
    logic [1:0]       crit_reg;
    logic             elem_reg;
    entry_t           lbl_reg, lbl_next;
    logic             mvalid_reg, mvalid_next;
    logic [OUT_DATA_W-1:0] mdata_reg, mdata_next;

    entry_t           in_lbl;
    logic [3:0]       len_in;
    entry_t           rd_ent;
    cmp_t             cmp;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    always_comb
    begin
        len_in = s_tdata[233:230];
        in_lbl.vertex   = s_tdata[5:0];
        in_lbl.weight   = s_tdata[37:6];
        in_lbl.path_len = (len_in > 4'(MAX_PATH)) ? 4'(MAX_PATH) : len_in;
        for (int i = 0; i < RES_LANES; i++)
        begin
            in_lbl.res[i*RES_W +: RES_W] = (i < NUM_RES) ?
                s_tdata[38 + i*RES_W +: RES_W] : '0;
        end
        for (int i = 0; i < MAP_W; i++)
        begin
            in_lbl.umap[i] = (i < NUM_NODES) ? s_tdata[102 + i] : 1'b0;
        end
        for (int i = 0; i < PATH_BYTES; i++)
        begin
            in_lbl.path[i*8 +: 8] = (4'(i) < in_lbl.path_len) ?
                s_tdata[166 + i*8 +: 8] : 8'd0;
        end
    end

    ldp_store #(.MAX_LABELS(MAX_LABELS)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_reg[IDX_W-1:0]),
        .rdata (rd_ent)
    );

    ldp_cmp u_cmp (
        .lbl  (lbl_reg),
        .ent  (rd_ent),
        .bwd  (bwd_reg),
        .crit (crit_reg),
        .elem (elem_reg),
        .res  (cmp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        wr_next     = wr_reg;
        rem_next    = rem_reg;
        pend_next   = 1'b0;
        dom_next    = dom_reg;
        full_next   = full_reg;
        bwd_next    = bwd_reg;
        lbl_next    = lbl_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        mem_we      = 1'b0;
        mem_waddr   = wr_reg[IDX_W-1:0];
        mem_wdata   = rd_ent;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    lbl_next = in_lbl;
                    bwd_next = s_tuser[1];
                    rd_next  = '0;
                    wr_next  = '0;
                    rem_next = '0;
                    dom_next = 1'b0;
                    full_next = 1'b0;
                    if (s_tuser[0] == REQ_APPEND)
                    begin
                        if (count_reg < CNT_W'(MAX_LABELS))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            mem_wdata  = in_lbl;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_reg < count_reg)
                begin
                    rd_next   = rd_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (!dom_reg && !cmp.same && cmp.new_dom)
                    begin
                        rem_next = rem_reg + 1'b1;
                    end
                    else
                    begin
                        if (!dom_reg && !cmp.same && cmp.ent_dom)
                        begin
                            dom_next = 1'b1;
                        end
                        mem_we  = 1'b1;
                        wr_next = wr_reg + 1'b1;
                    end
                end
                else if (rd_reg >= count_reg)
                begin
                    count_next = wr_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {2'b00, full_reg, 6'(count_reg), 6'(rem_reg), dom_reg};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_reg     <= '0;
            wr_reg     <= '0;
            rem_reg    <= '0;
            pend_reg   <= 1'b0;
            dom_reg    <= 1'b0;
            full_reg   <= 1'b0;
            bwd_reg    <= 1'b0;
            crit_reg   <= 2'd0;
            elem_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            rem_reg    <= rem_next;
            pend_reg   <= pend_next;
            dom_reg    <= dom_next;
            full_reg   <= full_next;
            bwd_reg    <= bwd_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we && cfg_addr == CFG_CRIT_IDX)
            begin
                crit_reg <= cfg_data;
            end
            if (cfg_we && cfg_addr == CFG_ELEM)
            begin
                elem_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lbl_reg   <= lbl_next;
        mdata_reg <= mdata_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LABELS))
        else $error("label count beyond store depth");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> wr_reg <= rd_reg)
        else $error("compaction write overtook read");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_SCAN)
        else $error("entry in flight outside scan");

    a_count_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_FIN) |=>
            count_reg == $past(count_reg) - $past(rem_reg))
        else $error("count does not match removals");

endmodule
`default_nettype wire

// ===== dv/label_dominance_prune_unit_tb.sv =====
// Testbench for label_dominance_prune_unit: random and directed check/append
// items, checked against a behavioural model of the label store.
// Depends on ldp_pkg and the unit RTL.
`timescale 1ns / 100ps
module label_dominance_prune_unit_tb
    import ldp_pkg::*;
();

    localparam int NLAB = 32;

    typedef struct packed {
        logic        req;
        logic        bwd;
        logic [5:0]  vtx;
        logic [31:0] w;
        logic [63:0] res;
        logic [63:0] umap;
        logic [63:0] path;
        logic [3:0]  len;
    } label_item_t;

    typedef struct packed {
        logic       dom;
        logic [5:0] removed;
        logic [5:0] stored;
        logic       full;
    } prune_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic cfg_addr = 1'b0;
    logic [1:0] cfg_data = '0;

    label_dominance_prune_unit dut (.*);

    always #1 clk = ~clk;

    label_item_t   pending_items[$];
    prune_result_t expected_results[$];

    logic [31:0] st_w[NLAB];
    logic [63:0] st_res[NLAB];
    logic [63:0] st_umap[NLAB];
    logic [63:0] st_path[NLAB];
    logic [9:0]  st_vl[NLAB];
    int          st_count;
    logic [1:0]  crit_idx;
    logic        elem_mode;

    int errors = 0;
    int cycles = 0;
    int hold_off = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit in_acc = 0;

    function automatic logic signed [15:0] lane(logic [63:0] r, int i);
        return r[16*i +: 16];
    endfunction

    function automatic bit label_dominates(logic [31:0] wa, logic [63:0] ra, logic [63:0] ua,
                                           logic [31:0] wb, logic [63:0] rb, logic [63:0] ub,
                                           bit bwd);
        if (wa == wb && ra == rb)
            return 0;
        if ($signed(wa) > $signed(wb))
            return 0;
        for (int i = 0; i < 4; i++)
        begin
            if (bwd && i == crit_idx)
            begin
                if (lane(ra, i) < lane(rb, i))
                    return 0;
            end
            else if (lane(ra, i) > lane(rb, i))
                return 0;
        end
        if (elem_mode && ua != 0 && ub != 0 && (ua & ~ub) != 0)
            return 0;
        return 1;
    endfunction

    function automatic prune_result_t predict_prune(label_item_t it);
        prune_result_t r;
        logic [3:0] len;
        logic [63:0] path;
        logic [9:0] vl;
        int k;
        r = '0;
        len = (it.len > 8) ? 4'd8 : it.len;
        path = (len >= 8) ? it.path : (it.path & ((64'd1 << (8 * len)) - 1));
        vl = {len, it.vtx};
        if (it.req == REQ_APPEND)
        begin
            if (st_count < NLAB)
            begin
                st_w[st_count] = it.w;
                st_res[st_count] = it.res;
                st_umap[st_count] = it.umap;
                st_path[st_count] = path;
                st_vl[st_count] = vl;
                st_count++;
            end
            else
                r.full = 1;
        end
        else
        begin
            k = 0;
            while (k < st_count)
            begin
                if (!(st_vl[k] == vl && st_w[k] == it.w && st_path[k] == path
                      && st_res[k] == it.res))
                begin
                    if (label_dominates(it.w, it.res, it.umap, st_w[k], st_res[k],
                                        st_umap[k], it.bwd))
                    begin
                        for (int j = k; j + 1 < st_count; j++)
                        begin
                            st_w[j] = st_w[j+1];
                            st_res[j] = st_res[j+1];
                            st_umap[j] = st_umap[j+1];
                            st_path[j] = st_path[j+1];
                            st_vl[j] = st_vl[j+1];
                        end
                        st_count--;
                        r.removed++;
                        continue;
                    end
                    if (label_dominates(st_w[k], st_res[k], st_umap[k], it.w, it.res,
                                        it.umap, it.bwd))
                    begin
                        r.dom = 1;
                        break;
                    end
                end
                k++;
            end
        end
        r.stored = 6'(st_count);
        return r;
    endfunction

    // Driver
    always @(negedge clk)
    begin
        label_item_t cur;
        if (rst_n)
        begin
            if (in_acc)
            begin
                cur = pending_items.pop_front();
                expected_results = {expected_results, predict_prune(cur)};
                send_wait = $urandom_range(0, 7);
            end
            if (pending_items.size() != 0 && send_wait == 0)
            begin
                s_tvalid <= 1'b1;
                s_tuser <= {pending_items[0].bwd, pending_items[0].req};
                s_tdata <= {6'd0, pending_items[0].len, pending_items[0].path,
                            pending_items[0].umap, pending_items[0].res,
                            pending_items[0].w, pending_items[0].vtx};
            end
            else
            begin
                s_tvalid <= 1'b0;
                if (send_wait > 0)
                    send_wait--;
            end
        end
    end

    // Receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        prune_result_t got, exp_r;
        cycles++;
        in_acc <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], m_tdata[6:1], m_tdata[12:7], m_tdata[13]};
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: dom %0d/%0d removed %0d/%0d",
                                  " stored %0d/%0d full %0d/%0d"},
                                 exp_r.dom, got.dom, exp_r.removed, got.removed,
                                 exp_r.stored, got.stored, exp_r.full, got.full);
                end
            end
            recv_wait <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
        end
        if (cycles > 400000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic label_item_t rand_item(bit near);
        label_item_t it;
        it.req = ($urandom_range(0, 2) == 0);
        it.bwd = 1'($urandom_range(0, 1));
        it.vtx = near ? 6'($urandom_range(0, 3)) : 6'($urandom);
        it.w = near ? $urandom_range(0, 7) - 4 : $urandom;
        for (int i = 0; i < 4; i++)
            it.res[16*i +: 16] = near ? 16'($urandom_range(0, 5) - 2) : 16'($urandom);
        it.umap = near ? 64'($urandom_range(0, 15)) : {$urandom, $urandom};
        it.path = {$urandom, $urandom};
        it.len = near ? 4'($urandom_range(0, 9)) : 4'($urandom);
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CRIT_IDX)
            crit_idx = val;
        else
            elem_mode = val[0];
    endtask

    initial
    begin
        label_item_t it;
        st_count = 0;
        crit_idx = 0;
        elem_mode = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: extremes, sixteen appends, then four checks
        for (int i = 0; i < 20; i++)
        begin
            it = rand_item(1);
            it.req = (i < 16) ? REQ_APPEND : REQ_CHECK;
            if (i == 0)
            begin
                it.w = 32'h8000_0000;
                it.res = {4{16'h8000}};
                it.umap = '1;
                it.path = '1;
                it.len = 4'hf;
                it.vtx = 6'h3f;
            end
            if (i == 1)
            begin
                it.w = 32'h7fff_ffff;
                it.res = {4{16'h7fff}};
                it.umap = '0;
                it.len = 4'd0;
            end
            pending_items = {pending_items, it};
        end
        drain();
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_CRIT_IDX, (p == 0) ? 2'd3 : (p == 1 ? 2'd0 : 2'($urandom)));
            write_reg(CFG_ELEM, {1'b0, p[0]});
            for (int i = 0; i < 34; i++)
                pending_items = {pending_items, rand_item($urandom_range(0, 4) != 0)};
            for (int i = 0; i < 34; i++)
            begin
                it = rand_item(1);
                it.req = REQ_APPEND;
                pending_items = {pending_items, it};
            end
            if (p == 2)
                hold_off = 300;
            drain();
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
